// ===== design/hslrgb_pkg.sv =====
`default_nettype none

package hslrgb_pkg;

   // Stream payload widths, padded to whole bytes.
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 24;

   // Field widths.
   localparam int unsigned HUE_W   = 9;
   localparam int unsigned CHAN_W  = 8;

   // Fixed point: 16 fraction bits; levels reach exactly one, so they need 17 bits.
   localparam int unsigned Q_FRAC  = 16;
   localparam int unsigned Q_W     = 17;
   localparam int unsigned PHASE_W = 16;
   // The ramp distance from a corner never exceeds one sixth of a turn.
   localparam int unsigned SLOPE_W = 14;

   // Register stages from the input beat to the output register.
   localparam int unsigned PIPE_DEPTH = 8;

   localparam logic [HUE_W-1:0]  HUE_RANGE = 9'd360;
   localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;

   // 65536 / 360 = 182 + 16/360, and floor(16*h/360) = floor(h*2914 / 2^16) for h < 360.
   localparam logic [7:0]  HUE_STEP  = 8'd182;
   localparam logic [11:0] HUE_RECIP = 12'd2914;

   localparam logic [PHASE_W-1:0] Q_THIRD      = 16'd21845;
   localparam logic [PHASE_W-1:0] Q_TWO_THIRDS = 16'd43690;
   localparam logic [Q_W-1:0]     Q_HALF       = 17'd32768;

   // Ramp segment bounds: 6t < 1, 2t < 1 and 3t < 2 turned into compares on t.
   localparam logic [PHASE_W-1:0] T_RISE_END = 16'd10923;
   localparam logic [PHASE_W-1:0] T_TOP_END  = 16'd32768;
   localparam logic [PHASE_W-1:0] T_FALL_END = 16'd43691;

   typedef enum logic [1:0] {
      RAMP_RISE,
      RAMP_TOP,
      RAMP_FALL,
      RAMP_BASE
   } ramp_region_type;

   // Load enables for the four stages inside a channel lane.
   typedef struct packed {
      logic seg_load;
      logic prod_load;
      logic level_load;
      logic chan_load;
   } lane_en_type;

endpackage

`default_nettype wire

// ===== design/hslrgb_lane.sv =====
`default_nettype none

module hslrgb_lane (
   input  logic                            clock,
   input  hslrgb_pkg::lane_en_type         en,
   input  logic                            flat,
   input  logic [hslrgb_pkg::CHAN_W-1:0]   flat_value,
   input  logic [hslrgb_pkg::PHASE_W-1:0]  phase,
   input  logic [hslrgb_pkg::Q_W-1:0]      level_lo,
   input  logic [hslrgb_pkg::Q_W-1:0]      level_hi,
   input  logic [hslrgb_pkg::Q_W-1:0]      level_span,
   output logic [hslrgb_pkg::CHAN_W-1:0]   channel
);
   import hslrgb_pkg::*;

   // Segment stage registers.
   ramp_region_type      s5_region_ff;
   ramp_region_type      region_in;
   logic [SLOPE_W-1:0]   s5_slope_ff;
   logic [SLOPE_W-1:0]   slope_in;
   logic [Q_W-1:0]       s5_span_ff;
   logic [Q_W-1:0]       s5_lo_ff;
   logic [Q_W-1:0]       s5_hi_ff;
   logic                 s5_flat_ff;
   logic [CHAN_W-1:0]    s5_flat_value_ff;

   // Product stage registers.
   logic [Q_W+SLOPE_W-1:0] s6_prod_ff;
   logic [Q_W+SLOPE_W-1:0] prod_in;
   ramp_region_type        s6_region_ff;
   logic [Q_W-1:0]         s6_lo_ff;
   logic [Q_W-1:0]         s6_hi_ff;
   logic                   s6_flat_ff;
   logic [CHAN_W-1:0]      s6_flat_value_ff;

   // Level stage registers.
   logic [Q_W+SLOPE_W+2:0] six_prod;
   logic [Q_W:0]           ramp_sum;
   logic [Q_W-1:0]         s7_level_ff;
   logic [Q_W-1:0]         level_in;
   logic                   s7_flat_ff;
   logic [CHAN_W-1:0]      s7_flat_value_ff;

   // Output stage.
   logic [Q_W+CHAN_W-1:0]  scaled;
   logic [CHAN_W:0]        chan_wide;
   logic [CHAN_W-1:0]      chan_ff;
   logic [CHAN_W-1:0]      chan_in;

   // Pick the ramp segment and the distance from its low corner.
   always_comb begin
      priority if (phase < T_RISE_END) begin
         region_in = RAMP_RISE;
      end else if (phase < T_TOP_END) begin
         region_in = RAMP_TOP;
      end else if (phase < T_FALL_END) begin
         region_in = RAMP_FALL;
      end else begin
         region_in = RAMP_BASE;
      end
   end

   always_comb begin
      unique case (region_in)
         RAMP_RISE: slope_in = phase[SLOPE_W-1:0];
         RAMP_FALL: slope_in = SLOPE_W'(Q_TWO_THIRDS - phase);
         default:   slope_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.seg_load) begin
         s5_region_ff     <= region_in;
         s5_slope_ff      <= slope_in;
         s5_span_ff       <= level_span;
         s5_lo_ff         <= level_lo;
         s5_hi_ff         <= level_hi;
         s5_flat_ff       <= flat;
         s5_flat_value_ff <= flat_value;
      end
   end

   // Span times distance.
   assign prod_in = (Q_W+SLOPE_W)'(s5_span_ff) * (Q_W+SLOPE_W)'(s5_slope_ff);

   always_ff @(posedge clock) begin
      if (en.prod_load) begin
         s6_prod_ff       <= prod_in;
         s6_region_ff     <= s5_region_ff;
         s6_lo_ff         <= s5_lo_ff;
         s6_hi_ff         <= s5_hi_ff;
         s6_flat_ff       <= s5_flat_ff;
         s6_flat_value_ff <= s5_flat_value_ff;
      end
   end

   // Six times the product, scaled back by 2^16, on top of the low level.
   assign six_prod = {s6_prod_ff, 2'b00} + {1'b0, s6_prod_ff, 1'b0};
   assign ramp_sum = (Q_W+1)'(s6_lo_ff) + (Q_W+1)'(six_prod[Q_FRAC+Q_W-1:Q_FRAC]);

   always_comb begin
      unique case (s6_region_ff)
         RAMP_RISE, RAMP_FALL: level_in = ramp_sum[Q_W-1:0];
         RAMP_TOP:             level_in = s6_hi_ff;
         RAMP_BASE:            level_in = s6_lo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.level_load) begin
         s7_level_ff      <= level_in;
         s7_flat_ff       <= s6_flat_ff;
         s7_flat_value_ff <= s6_flat_value_ff;
      end
   end

   // 255 times the level, truncated to the integer part and saturated.
   assign scaled    = {s7_level_ff, {CHAN_W{1'b0}}} - (Q_W+CHAN_W)'(s7_level_ff);
   assign chan_wide = scaled[Q_W+CHAN_W-1:Q_FRAC];
   assign chan_in   = s7_flat_ff    ? s7_flat_value_ff :
                      chan_wide[CHAN_W] ? CHAN_MAX : chan_wide[CHAN_W-1:0];

   always_ff @(posedge clock) begin
      if (en.chan_load) begin
         chan_ff <= chan_in;
      end
   end

   assign channel = chan_ff;

endmodule

`default_nettype wire

// ===== design/hsl_to_rgb_converter.sv =====
// Throughput is one pixel per clock while the output side is ready, set by the fully
// pipelined datapath. Each stage holds its beat while the next one is full and stalled,
// and empty stages fill in behind a stall; req_tready follows rsp_tready combinationally
// only once every stage is full.
// Synchronous active-high reset clears every stage's valid bit; req_tready is low in reset.
`default_nettype none

module hsl_to_rgb_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [8:0] hue_degrees, [16:9] saturation, [24:17] lightness, [31:25] zero
   input  logic [hslrgb_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [hslrgb_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import hslrgb_pkg::*;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH:0]   adv;

   logic [HUE_W-1:0]  req_hue;
   logic [CHAN_W-1:0] req_sat;
   logic [CHAN_W-1:0] req_lig;

   // Stage 1: hue reduced, fractions in fixed point.
   logic [HUE_W-1:0]  s1_hue_ff;
   logic [HUE_W-1:0]  hue_in;
   logic [Q_W-1:0]    s1_sat_q_ff;
   logic [Q_W-1:0]    sat_q_in;
   logic [Q_W-1:0]    s1_lig_q_ff;
   logic [Q_W-1:0]    lig_q_in;
   logic              s1_flat_ff;
   logic [CHAN_W-1:0] s1_lig_ff;

   // Stage 2: product of lightness and saturation, hue in fixed point.
   logic [2*Q_W-1:0]   ls_prod;
   logic [Q_W-1:0]     s2_ls_ff;
   logic [PHASE_W-1:0] hue_coarse;
   logic [20:0]        hue_fine_prod;
   logic [PHASE_W-1:0] s2_hue_q_ff;
   logic [PHASE_W-1:0] hue_q_in;
   logic [Q_W-1:0]     s2_sat_q_ff;
   logic [Q_W-1:0]     s2_lig_q_ff;
   logic               s2_flat_ff;
   logic [CHAN_W-1:0]  s2_lig_ff;

   // Stage 3: upper level and the three ramp phases.
   logic [Q_W:0]       v2_wide;
   logic [Q_W-1:0]     s3_v2_ff;
   logic [Q_W-1:0]     s3_lig_q_ff;
   logic [PHASE_W-1:0] s3_green_t_ff;
   logic [PHASE_W-1:0] s3_red_t_ff;
   logic [PHASE_W-1:0] s3_blue_t_ff;
   logic               s3_flat_ff;
   logic [CHAN_W-1:0]  s3_lig_ff;

   // Stage 4: lower level and span.
   logic [Q_W:0]       two_l;
   logic               lo_positive;
   logic [Q_W-1:0]     v1_in;
   logic [Q_W-1:0]     v2_in;
   logic [Q_W-1:0]     span_in;
   logic [Q_W-1:0]     s4_v1_ff;
   logic [Q_W-1:0]     s4_v2_ff;
   logic [Q_W-1:0]     s4_span_ff;
   logic [PHASE_W-1:0] s4_green_t_ff;
   logic [PHASE_W-1:0] s4_red_t_ff;
   logic [PHASE_W-1:0] s4_blue_t_ff;
   logic               s4_flat_ff;
   logic [CHAN_W-1:0]  s4_lig_ff;

   lane_en_type       lane_en;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   // A stage may load when it is empty or the stage after it moves on.
   always_comb begin
      adv[PIPE_DEPTH] = rsp_tready;
      for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[0] && !reset;

   always_comb begin
      if (adv[0]) begin
         valid_in[0] = req_tvalid && req_tready;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         if (adv[i]) begin
            valid_in[i] = valid_ff[i-1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_hue = req_tdata[HUE_W-1:0];
   assign req_sat = req_tdata[HUE_W+CHAN_W-1:HUE_W];
   assign req_lig = req_tdata[HUE_W+2*CHAN_W-1:HUE_W+CHAN_W];

   // Stage 1: x*65536/255 is x*257, plus one when x is full scale.
   assign hue_in   = (req_hue >= HUE_RANGE) ? HUE_W'(req_hue - HUE_RANGE) : req_hue;
   assign sat_q_in = Q_W'({req_sat, req_sat}) + Q_W'(req_sat == CHAN_MAX);
   assign lig_q_in = Q_W'({req_lig, req_lig}) + Q_W'(req_lig == CHAN_MAX);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_hue_ff   <= hue_in;
         s1_sat_q_ff <= sat_q_in;
         s1_lig_q_ff <= lig_q_in;
         s1_flat_ff  <= (req_sat == '0);
         s1_lig_ff   <= req_lig;
      end
   end

   // Stage 2: L*S in Q16 and hue*65536/360 as a coarse step plus a small correction.
   assign ls_prod       = (2*Q_W)'(s1_lig_q_ff) * (2*Q_W)'(s1_sat_q_ff);
   assign hue_coarse    = PHASE_W'(PHASE_W'(s1_hue_ff) * PHASE_W'(HUE_STEP));
   assign hue_fine_prod = 21'(s1_hue_ff) * 21'(HUE_RECIP);
   assign hue_q_in      = hue_coarse + PHASE_W'(hue_fine_prod[20:Q_FRAC]);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_ls_ff    <= ls_prod[Q_W+Q_FRAC-1:Q_FRAC];
         s2_hue_q_ff <= hue_q_in;
         s2_sat_q_ff <= s1_sat_q_ff;
         s2_lig_q_ff <= s1_lig_q_ff;
         s2_flat_ff  <= s1_flat_ff;
         s2_lig_ff   <= s1_lig_ff;
      end
   end

   // Stage 3: upper level; the phases wrap naturally in 16 bits.
   assign v2_wide = (s2_lig_q_ff < Q_HALF) ?
                    ((Q_W+1)'(s2_lig_q_ff) + (Q_W+1)'(s2_ls_ff)) :
                    ((Q_W+1)'(s2_lig_q_ff) + (Q_W+1)'(s2_sat_q_ff) - (Q_W+1)'(s2_ls_ff));

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_v2_ff      <= v2_wide[Q_W-1:0];
         s3_lig_q_ff   <= s2_lig_q_ff;
         s3_green_t_ff <= s2_hue_q_ff;
         s3_red_t_ff   <= s2_hue_q_ff + Q_THIRD;
         s3_blue_t_ff  <= s2_hue_q_ff - Q_THIRD;
         s3_flat_ff    <= s2_flat_ff;
         s3_lig_ff     <= s2_lig_ff;
      end
   end

   // Stage 4: v1 = 2L - v2 clamped at zero, v2 raised to v1 if needed, and their span.
   // Where v1 is not clamped, the span 2*v2 - 2L is formed beside v1 so that no subtract waits on another.
   assign two_l       = {s3_lig_q_ff, 1'b0};
   assign lo_positive = (two_l >= (Q_W+1)'(s3_v2_ff));
   assign v1_in       = lo_positive ? Q_W'(two_l - (Q_W+1)'(s3_v2_ff)) : '0;

   always_comb begin
      if (!lo_positive) begin
         v2_in   = s3_v2_ff;
         span_in = s3_v2_ff;
      end else if (s3_v2_ff >= s3_lig_q_ff) begin
         v2_in   = s3_v2_ff;
         span_in = Q_W'({s3_v2_ff - s3_lig_q_ff, 1'b0});
      end else begin
         v2_in   = v1_in;
         span_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_v1_ff      <= v1_in;
         s4_v2_ff      <= v2_in;
         s4_span_ff    <= span_in;
         s4_green_t_ff <= s3_green_t_ff;
         s4_red_t_ff   <= s3_red_t_ff;
         s4_blue_t_ff  <= s3_blue_t_ff;
         s4_flat_ff    <= s3_flat_ff;
         s4_lig_ff     <= s3_lig_ff;
      end
   end

   // Stages 5 to 8 run in one lane per channel.
   assign lane_en.seg_load   = adv[4];
   assign lane_en.prod_load  = adv[5];
   assign lane_en.level_load = adv[6];
   assign lane_en.chan_load  = adv[7];

   hslrgb_lane u_red_lane (
      .clock      (clock),
      .en         (lane_en),
      .flat       (s4_flat_ff),
      .flat_value (s4_lig_ff),
      .phase      (s4_red_t_ff),
      .level_lo   (s4_v1_ff),
      .level_hi   (s4_v2_ff),
      .level_span (s4_span_ff),
      .channel    (red)
   );

   hslrgb_lane u_green_lane (
      .clock      (clock),
      .en         (lane_en),
      .flat       (s4_flat_ff),
      .flat_value (s4_lig_ff),
      .phase      (s4_green_t_ff),
      .level_lo   (s4_v1_ff),
      .level_hi   (s4_v2_ff),
      .level_span (s4_span_ff),
      .channel    (green)
   );

   hslrgb_lane u_blue_lane (
      .clock      (clock),
      .en         (lane_en),
      .flat       (s4_flat_ff),
      .flat_value (s4_lig_ff),
      .phase      (s4_blue_t_ff),
      .level_lo   (s4_v1_ff),
      .level_hi   (s4_v2_ff),
      .level_span (s4_span_ff),
      .channel    (blue)
   );

   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {blue, green, red};

endmodule

`default_nettype wire

// ===== design/hslrgb_checker.sv =====
`default_nettype none

module hslrgb_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [hslrgb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [hslrgb_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A beat accepted at the input, with the output side ready and no reset in every cycle since.
   sequence s_clear_path;
      $past(req_tvalid && req_tready, 8) &&
      $past(rsp_tready, 1) && $past(rsp_tready, 2) && $past(rsp_tready, 3) &&
      $past(rsp_tready, 4) && $past(rsp_tready, 5) && $past(rsp_tready, 6) &&
      $past(rsp_tready, 7) &&
      !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4) &&
      !$past(reset, 5) && !$past(reset, 6) && !$past(reset, 7);
   endsequence

   // Reset empties the pipeline.
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat offered right after reset");

   // With the output side ready and no reset, an accepted beat comes out as a result beat.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      s_clear_path |-> rsp_tvalid)
      else $error("result beat missing after pipeline latency");

   // Zero saturation gives lightness on all three channels.
   a_gray: assert property (@(posedge clock) disable iff (reset)
      s_clear_path ##0 ($past(req_tdata[16:9], 8) == 8'd0) |->
         (rsp_tdata[7:0] == $past(req_tdata[24:17], 8)) &&
         (rsp_tdata[15:8] == $past(req_tdata[24:17], 8)) &&
         (rsp_tdata[23:16] == $past(req_tdata[24:17], 8)))
      else $error("gray pixel channels differ from lightness");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

endmodule

bind hsl_to_rgb_converter hslrgb_checker u_checker (.*);

`default_nettype wire
